// ===== rtl/fnrs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fnrs_pkg;

  localparam int unsigned NUM_CHANNELS = 9;
  localparam int unsigned INSTRUMENTS  = 5;
  localparam int unsigned PATCH_ROWS   = 5;
  localparam int unsigned PATCH_COLS   = 11;

  localparam logic MODE_ON  = 1'b0;
  localparam logic MODE_OFF = 1'b1;

  // fnum = hz * 2^20 / DIVISOR from a reciprocal product, which can come out one low
  localparam logic [15:0]       DIVISOR  = 16'd49716;
  localparam int unsigned       RECIP_SH = 16;
  localparam int unsigned       QUOT_W   = 21;
  localparam logic [QUOT_W-1:0] RECIP    = QUOT_W'((64'd1 << (20 + RECIP_SH)) / 64'(DIVISOR));
  localparam logic [1:0]        DIV_LAST = 2'd3;
  localparam logic [9:0]        FNUM_MAX = 10'd1023;

  localparam logic [7:0] REG_MULT  = 8'h20;
  localparam logic [7:0] REG_LEVEL = 8'h40;
  localparam logic [7:0] REG_AD    = 8'h60;
  localparam logic [7:0] REG_SR    = 8'h80;
  localparam logic [7:0] REG_WAVE  = 8'hE0;
  localparam logic [7:0] REG_FNLO  = 8'hA0;
  localparam logic [7:0] REG_KEY   = 8'hB0;
  localparam logic [7:0] REG_FB    = 8'hC0;

  localparam logic [5:0] KEY_ON_BIT = 6'h20;
  localparam logic [5:0] LEVEL_MAX  = 6'd63;

  // columns: mod mult, level, ad, sr, wave, car mult, level, ad, sr, wave, feedback
  localparam logic [3:0] COL_FB = 4'd10;
  localparam logic [7:0] PATCH_ROM [PATCH_ROWS][PATCH_COLS] = '{
    '{8'h01, 8'h00, 8'hF3, 8'h75, 8'h00, 8'h01, 8'h00, 8'hF3, 8'h75, 8'h00, 8'h0E},
    '{8'h02, 8'h00, 8'hA5, 8'h33, 8'h00, 8'h02, 8'h00, 8'hA5, 8'h33, 8'h00, 8'h06},
    '{8'h05, 8'h00, 8'hF0, 8'h97, 8'h01, 8'h02, 8'h00, 8'hF0, 8'hA7, 8'h00, 8'h0A},
    '{8'h00, 8'h00, 8'hF8, 8'h65, 8'h00, 8'h00, 8'h00, 8'hF6, 8'h65, 8'h00, 8'h08},
    '{8'h21, 8'h00, 8'hFF, 8'h08, 8'h00, 8'h21, 8'h00, 8'hFF, 8'h08, 8'h00, 8'h0E}
  };

  typedef enum logic [1:0] {
    OFS_CH,
    OFS_MOD,
    OFS_CAR
  } addr_sel_e;

  typedef enum logic [2:0] {
    D_KEYOFF,
    D_PATCH,
    D_VOL,
    D_FNLO,
    D_KEYON
  } data_sel_e;

  typedef enum logic [1:0] {
    J_NEXT,
    J_END_OFF,
    J_END
  } jump_e;

  typedef struct packed {
    logic [7:0] addr_base;
    addr_sel_e  addr_sel;
    data_sel_e  data_sel;
    logic [3:0] patch_col;
    logic       wait_fnum;
    logic       store_key;
    jump_e      jump;
  } ucode_t;

  typedef struct packed {
    logic       mode;
    logic [3:0] ch;
    logic [2:0] row;
    logic [5:0] car_level;
  } cmd_t;

  typedef struct packed {
    logic       done;
    logic [2:0] block;
    logic [9:0] fnum;
  } fnum_t;

  function automatic ucode_t ucode_word(input logic [3:0] step);
    ucode_t w;
    w = '{addr_base: REG_KEY, addr_sel: OFS_CH, data_sel: D_KEYOFF, patch_col: 4'd0,
          wait_fnum: 1'b0, store_key: 1'b0, jump: J_NEXT};
    unique case (step)
      4'd0:  w.jump = J_END_OFF;
      4'd1:  w = '{REG_MULT,  OFS_MOD, D_PATCH, 4'd0, 1'b0, 1'b0, J_NEXT};
      4'd2:  w = '{REG_LEVEL, OFS_MOD, D_PATCH, 4'd1, 1'b0, 1'b0, J_NEXT};
      4'd3:  w = '{REG_AD,    OFS_MOD, D_PATCH, 4'd2, 1'b0, 1'b0, J_NEXT};
      4'd4:  w = '{REG_SR,    OFS_MOD, D_PATCH, 4'd3, 1'b0, 1'b0, J_NEXT};
      4'd5:  w = '{REG_WAVE,  OFS_MOD, D_PATCH, 4'd4, 1'b0, 1'b0, J_NEXT};
      4'd6:  w = '{REG_MULT,  OFS_CAR, D_PATCH, 4'd5, 1'b0, 1'b0, J_NEXT};
      4'd7:  w = '{REG_LEVEL, OFS_CAR, D_VOL,   4'd6, 1'b0, 1'b0, J_NEXT};
      4'd8:  w = '{REG_AD,    OFS_CAR, D_PATCH, 4'd7, 1'b0, 1'b0, J_NEXT};
      4'd9:  w = '{REG_SR,    OFS_CAR, D_PATCH, 4'd8, 1'b0, 1'b0, J_NEXT};
      4'd10: w = '{REG_WAVE,  OFS_CAR, D_PATCH, 4'd9, 1'b0, 1'b0, J_NEXT};
      4'd11: w = '{REG_FB,    OFS_CH,  D_PATCH, COL_FB, 1'b0, 1'b0, J_NEXT};
      4'd12: w = '{REG_FNLO,  OFS_CH,  D_FNLO,  4'd0, 1'b1, 1'b0, J_NEXT};
      4'd13: w = '{REG_KEY,   OFS_CH,  D_KEYON, 4'd0, 1'b1, 1'b1, J_END};
      default: w.jump = J_END;
    endcase
    return w;
  endfunction

  function automatic logic [4:0] mod_slot(input logic [3:0] ch);
    logic [4:0] s;
    unique case (ch)
      4'd0: s = 5'd0;
      4'd1: s = 5'd1;
      4'd2: s = 5'd2;
      4'd3: s = 5'd6;
      4'd4: s = 5'd7;
      4'd5: s = 5'd8;
      4'd6: s = 5'd12;
      4'd7: s = 5'd13;
      4'd8: s = 5'd14;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

  // carrier slot sits three above its modulator
  function automatic logic [4:0] car_slot(input logic [3:0] ch);
    return mod_slot(ch) + 5'd3;
  endfunction

  function automatic logic [7:0] patch_byte(input logic [2:0] row, input logic [3:0] col);
    logic [7:0] b;
    b = 8'h00;
    if ((32'(row) < PATCH_ROWS) && (32'(col) < PATCH_COLS)) begin
      b = PATCH_ROM[row][col];
    end
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/fnrs_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fnrs_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [15:0]        freq_hz_i,
  output fnrs_pkg::fnum_t         fnum_o
);
  import fnrs_pkg::*;

  logic              run_q;
  logic [1:0]        cnt_q;
  logic              done_q;
  logic [15:0]       hz_q;
  logic [QUOT_W-1:0] est_q, est_d;
  logic [16:0]       rem_q, rem_d;
  logic [QUOT_W-1:0] quot_q, quot_d;
  logic [2:0]        block_q, block_d;
  logic [9:0]        fnum_q, fnum_d;

  // reciprocal product, truncated, is the quotient or one below it
  always_comb begin
    logic [36:0] prod;
    prod  = 37'(hz_q) * 37'(RECIP);
    est_d = prod[RECIP_SH +: QUOT_W];
  end

  // remainder left by the estimate, below twice the divisor
  always_comb begin
    logic [36:0] back;
    logic [36:0] diff;
    back  = 37'(est_q) * 37'(DIVISOR);
    diff  = {1'b0, hz_q, 20'd0} - back;
    rem_d = diff[16:0];
  end

  assign quot_d = (rem_q >= {1'b0, DIVISOR}) ? (est_q + QUOT_W'(1)) : est_q;

  // block is the fewest halvings that bring fnum into ten bits, at most seven
  always_comb begin
    logic [7:0]        fits;
    logic [2:0]        blk;
    logic [QUOT_W-1:0] sh;
    for (int b = 0; b < 8; b++) begin
      fits[b] = (quot_q >> b) <= QUOT_W'(FNUM_MAX);
    end
    blk = 3'd7;
    for (int b = 7; b >= 0; b--) begin
      if (fits[b]) begin
        blk = 3'(b);
      end
    end
    sh = quot_q >> blk;
    block_d = blk;
    fnum_d  = (sh > QUOT_W'(FNUM_MAX)) ? FNUM_MAX : sh[9:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      run_q  <= 1'b1;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (run_q) begin
      if (cnt_q == DIV_LAST) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q + 2'd1;
      end
    end
  end

  // estimate, remainder, fix-up, normalization: one stage per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      hz_q <= freq_hz_i;
    end
    if (run_q) begin
      case (cnt_q)
        2'd0: est_q <= est_d;
        2'd1: rem_q <= rem_d;
        2'd2: quot_q <= quot_d;
        default: begin
          block_q <= block_d;
          fnum_q  <= fnum_d;
        end
      endcase
    end
  end

  assign fnum_o = {done_q, block_q, fnum_q};

endmodule

`default_nettype wire

// ===== rtl/fnrs_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fnrs_seq (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  fnrs_pkg::cmd_t    cmd_i,
  input  fnrs_pkg::fnum_t   fnum_i,
  output logic              busy_o,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [15:0]       m_axis_tdata,   // reg_addr[7:0], reg_data[15:8]
  output logic              m_axis_tlast
);
  import fnrs_pkg::*;

  logic       run_q;
  logic [3:0] step_q;
  cmd_t       cmd_q;
  logic [5:0] key_q [NUM_CHANNELS];

  logic       out_valid_q;
  logic [7:0] out_addr_q;
  logic [7:0] out_data_q;
  logic       out_last_q;

  ucode_t     uw;
  logic [4:0] ofs;
  logic [7:0] addr;
  logic [7:0] data;
  logic [5:0] key_rd;
  logic [5:0] key_on;
  logic       last;
  logic       load;

  assign uw     = ucode_word(step_q);
  assign key_rd = key_q[cmd_q.ch];
  assign key_on = KEY_ON_BIT | {1'b0, fnum_i.block, fnum_i.fnum[9:8]};

  always_comb begin
    unique case (uw.addr_sel)
      OFS_MOD: ofs = mod_slot(cmd_q.ch);
      OFS_CAR: ofs = car_slot(cmd_q.ch);
      default: ofs = {1'b0, cmd_q.ch};
    endcase
    addr = uw.addr_base + {3'b000, ofs};
  end

  always_comb begin
    unique case (uw.data_sel)
      D_PATCH: data = patch_byte(cmd_q.row, uw.patch_col);
      D_VOL:   data = {2'b00, cmd_q.car_level};
      D_FNLO:  data = fnum_i.fnum[7:0];
      D_KEYON: data = {2'b00, key_on};
      default: data = {3'b000, key_rd[4:0]};
    endcase
  end

  assign last = (uw.jump == J_END) || ((uw.jump == J_END_OFF) && (cmd_q.mode == MODE_OFF));
  assign load = run_q && (!uw.wait_fnum || fnum_i.done) && (!out_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q       <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        key_q[i] <= '0;
      end
    end else begin
      if (start_i) begin
        run_q  <= 1'b1;
        step_q <= '0;
      end else if (load) begin
        if (last) begin
          run_q <= 1'b0;
        end else begin
          step_q <= step_q + 4'd1;
        end
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (load && uw.store_key) begin
        key_q[cmd_q.ch] <= key_on;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      cmd_q <= cmd_i;
    end
    if (load) begin
      out_addr_q <= addr;
      out_data_q <= data;
      out_last_q <= last;
    end
  end

  assign busy_o        = run_q;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_data_q, out_addr_q};
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

// ===== rtl/fm_note_register_sequencer_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Turns note-on and note-off commands for a nine-channel two-operator FM
// synthesizer into register writes (address in tdata[7:0], data in
// tdata[15:8], tlast on the final write of a command). A note-off gives one
// write, the key-off byte; a note-on gives fourteen: key-off, ten operator
// writes from the patch ROM with the carrier level set from the volume,
// feedback, fnum low and key-on. Commands for channels above eight, or any
// command while device_present is zero, are taken and produce nothing. One
// command is worked at a time: the microcode step counter issues one write per
// cycle when the output side is not stalling and, for the fnum low and key-on
// writes, the frequency number is done. The frequency number comes from a
// reciprocal multiply with a one-step fix-up and the block normalization,
// worked out alongside the first writes. The per-channel key bytes reset to
// zero and device_present resets to one.
module fm_note_register_sequencer_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // channel[3:0], freq_hz[19:4], volume[26:20],
                                           // instrument[29:27], zero fill[31:30]
  input  wire logic        s_axis_tuser,   // mode: 0 note on, 1 note off
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // reg_addr[7:0], reg_data[15:8]
  output logic             m_axis_tlast,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_data_i
);
  import fnrs_pkg::*;

  logic        present_q;
  logic        busy;
  logic        start;
  logic [3:0]  ch;
  logic [15:0] freq_hz;
  logic [6:0]  volume;
  logic [2:0]  instrument;
  cmd_t        cmd;
  fnum_t       fnum;

  assign ch         = s_axis_tdata[3:0];
  assign freq_hz    = s_axis_tdata[19:4];
  assign volume     = s_axis_tdata[26:20];
  assign instrument = s_axis_tdata[29:27];

  always_comb begin
    cmd.mode = s_axis_tuser;
    cmd.ch   = ch;
    // unknown instruments fall back to patch 0
    if ((32'(instrument) >= INSTRUMENTS) || (32'(instrument) >= PATCH_ROWS)) begin
      cmd.row = 3'd0;
    end else begin
      cmd.row = instrument;
    end
    cmd.car_level = (volume > {1'b0, LEVEL_MAX}) ? 6'd0 : (LEVEL_MAX - volume[5:0]);
  end

  assign s_axis_tready = !busy;
  assign start = s_axis_tvalid && s_axis_tready && present_q && (32'(ch) < NUM_CHANNELS);
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      present_q <= cfg_data_i;
    end
  end

  fnrs_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .freq_hz_i (freq_hz),
    .fnum_o    (fnum)
  );

  fnrs_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .cmd_i         (cmd),
    .fnum_i        (fnum),
    .busy_o        (busy),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire
